@@ design/esl_pkg.sv @@
// ============================================================================
// esl_pkg
// Shared types and constants of the encoder stepper lock controller.
// ============================================================================
package esl_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OPEN_TH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_TH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_TH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_TH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROT   = 3'd6;

    localparam logic signed [15:0] RST_OPEN_TH   = 16'sd0;
    localparam logic signed [15:0] RST_CLOSED_TH = 16'sd700;
    localparam logic signed [15:0] RST_FIRST_TH  = 16'sd175;
    localparam logic signed [15:0] RST_SECOND_TH = 16'sd525;
    localparam logic signed [15:0] RST_ZERO_TH   = 16'sd0;
    localparam logic signed [15:0] RST_MAX_TH    = 16'sd800;
    localparam logic [15:0]        RST_MAX_ROT   = 16'd2000;

    // Item kinds
    localparam logic [1:0] KIND_ENC  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_CMD  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // Commands
    localparam logic [1:0] CMD_OPEN  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_MOVE  = 2'd3;

    // Lock states
    localparam logic [2:0] ST_OPEN      = 3'd0;
    localparam logic [2:0] ST_FIRSTLOCK = 3'd1;
    localparam logic [2:0] ST_CLOSED    = 3'd2;
    localparam logic [2:0] ST_OPENING   = 3'd3;
    localparam logic [2:0] ST_CLOSING   = 3'd4;
    localparam logic [2:0] ST_MOVING    = 3'd5;
    localparam logic [2:0] ST_STOPPING  = 3'd6;

    // Move direction codes
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // Percent scaling: target = trunc(pct * closed / 100)
    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam int PROD_W  = 24;   // 8b signed pct times 16b signed threshold
    localparam int MAG_W   = 22;   // |product| <= 100 * 32768 < 2**22
    localparam int RECIP_S = 29;   // ceil(2**29 / 100), exact for MAG_W bits
    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
    localparam int QUOT_W  = 17;

    // Configuration registers
    typedef struct packed {
        logic signed [15:0] open_th;
        logic signed [15:0] closed_th;
        logic signed [15:0] first_th;
        logic signed [15:0] second_th;
        logic signed [15:0] zero_th;
        logic signed [15:0] max_th;
        logic [15:0]        max_rot;
    } t_cfg;

    // One classified item, as carried from the front to the back
    typedef struct packed {
        logic [1:0]         kind;
        logic               pin_a;
        logic               pin_b;
        logic [1:0]         command;
        logic signed [15:0] target;
    } t_item;

endpackage

@@ design/esl_front.sv @@
// ============================================================================
// esl_front
// Input stage: takes items, computes the move target in two stages.
// ============================================================================
module esl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  esl_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_kind,
    input  logic                 i_pin_a,
    input  logic                 i_pin_b,
    input  logic [1:0]           i_command,
    input  logic [6:0]           i_target_percent,
    output logic                 o_valid,
    input  logic                 i_ready,
    output esl_pkg::t_item       o_item
);
    import esl_pkg::*;

    logic                      r_s1_valid;
    logic [1:0]                r_s1_kind;
    logic                      r_s1_pin_a;
    logic                      r_s1_pin_b;
    logic [1:0]                r_s1_command;
    logic signed [PROD_W-1:0]  r_s1_prod;
    logic                      r_s2_valid;
    t_item                     r_s2_item;

    logic                      s1_adv;
    logic                      s2_adv;
    logic [6:0]                pct_clamp;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  prod_abs;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W+RECIP_W-1:0]  scaled;
    logic [QUOT_W-1:0]         quot;
    logic signed [QUOT_W-1:0]  n_target;

    // Stall control: each stage moves when the next one has room
    assign s2_adv  = !r_s2_valid || i_ready;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign o_ready = s1_adv;
    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;

    // Stage 1: clamp percent and multiply by the closed threshold
    assign pct_clamp = (i_target_percent > PCT_MAX) ? PCT_MAX : i_target_percent;
    assign n_prod    = PROD_W'($signed({1'b0, pct_clamp})) * PROD_W'(i_cfg.closed_th);

    // Stage 2: divide by 100 through the reciprocal, truncating toward zero
    assign prod_abs = r_s1_prod[PROD_W-1] ? -r_s1_prod : r_s1_prod;
    assign mag      = prod_abs[MAG_W-1:0];
    assign scaled   = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(RECIP_100);
    assign quot     = scaled[RECIP_S +: QUOT_W];
    assign n_target = r_s1_prod[PROD_W-1] ? -$signed(quot) : $signed(quot);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_s1_kind    <= i_kind;
            r_s1_pin_a   <= i_pin_a;
            r_s1_pin_b   <= i_pin_b;
            r_s1_command <= i_command;
            r_s1_prod    <= n_prod;
        end
        if (s2_adv && r_s1_valid) begin
            r_s2_item.kind    <= r_s1_kind;
            r_s2_item.pin_a   <= r_s1_pin_a;
            r_s2_item.pin_b   <= r_s1_pin_b;
            r_s2_item.command <= r_s1_command;
            r_s2_item.target  <= n_target[15:0];
        end
    end

endmodule

@@ design/esl_queue.sv @@
// ============================================================================
// esl_queue
// Two-entry item queue between the front and the back.
// ============================================================================
module esl_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  esl_pkg::t_item       i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output esl_pkg::t_item       o_item
);
    import esl_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ design/esl_back.sv @@
// ============================================================================
// esl_back
// Execution stage: decoder, motion state machine and result register.
// ============================================================================
module esl_back #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  esl_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  esl_pkg::t_item       i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_step_pulse,
    output logic                 o_motor_enable,
    output logic                 o_direction,
    output logic [2:0]           o_lock_status,
    output logic signed [15:0]   o_position,
    output logic                 o_failed
);
    import esl_pkg::*;

    localparam int CW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

    // Architectural state
    logic signed [POSITION_BITS-1:0] r_pos, n_pos;
    logic [1:0]                      r_last_pins, n_last_pins;
    logic [2:0]                      r_state, n_state;
    logic [15:0]                     r_rot, n_rot;
    logic signed [15:0]              r_target, n_target;
    logic [1:0]                      r_sign, n_sign;
    logic                            r_enable, n_enable;
    logic                            r_dir, n_dir;

    // Result register
    logic                            r_out_valid;
    logic                            r_step, n_step;
    logic                            r_fail, n_fail;
    logic signed [15:0]              r_out_pos;

    logic                            take;
    logic [3:0]                      pin_code;
    logic                            enc_up;
    logic                            enc_down;
    logic signed [CW-1:0]            pos_x;
    logic signed [CW-1:0]            n_pos_x;
    logic signed [CW-1:0]            tgt_x;
    logic signed [CW-1:0]            cmd_tgt_x;
    logic [2:0]                      settled;
    logic                            rot_over;
    logic [15:0]                     rot_inc;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    assign pos_x     = CW'(r_pos);
    assign n_pos_x   = CW'(n_pos);
    assign tgt_x     = CW'(r_target);
    assign cmd_tgt_x = CW'(i_item.target);

    // Quadrature transition decode
    assign pin_code = {r_last_pins, i_item.pin_a, i_item.pin_b};
    assign enc_up   = (pin_code == 4'b1101) || (pin_code == 4'b0100) ||
                      (pin_code == 4'b0010) || (pin_code == 4'b1011);
    assign enc_down = (pin_code == 4'b1110) || (pin_code == 4'b0111) ||
                      (pin_code == 4'b0001) || (pin_code == 4'b1000);

    // Resting state from position
    always_comb begin
        if (pos_x <= CW'(i_cfg.first_th)) begin
            settled = ST_OPEN;
        end else if (pos_x >= CW'(i_cfg.second_th)) begin
            settled = ST_CLOSED;
        end else begin
            settled = ST_FIRSTLOCK;
        end
    end

    // Step count limit, checked on the count before the step
    assign rot_over = (r_rot > i_cfg.max_rot);
    assign rot_inc  = (r_rot != 16'hFFFF) ? r_rot + 16'd1 : r_rot;

    // Next state for one item
    always_comb begin
        n_pos       = r_pos;
        n_last_pins = r_last_pins;
        n_state     = r_state;
        n_rot       = r_rot;
        n_target    = r_target;
        n_sign      = r_sign;
        n_enable    = r_enable;
        n_dir       = r_dir;
        n_step      = 1'b0;
        n_fail      = 1'b0;
        unique case (i_item.kind)
            KIND_ENC: begin
                n_last_pins = {i_item.pin_a, i_item.pin_b};
                if (enc_up && (r_pos != POS_MAX)) begin
                    n_pos = r_pos + 1'b1;
                end else if (enc_down && (r_pos != POS_MIN)) begin
                    n_pos = r_pos - 1'b1;
                end
            end
            KIND_TICK: begin
                unique case (r_state)
                    ST_STOPPING: begin
                        n_state  = settled;
                        n_enable = 1'b0;
                    end
                    ST_OPENING: begin
                        if (pos_x > CW'(i_cfg.open_th)) begin
                            n_step = 1'b1;
                            n_rot  = rot_inc;
                            if (rot_over || (pos_x < CW'(i_cfg.zero_th))) begin
                                n_enable = 1'b0;
                                n_state  = settled;
                                n_fail   = 1'b1;
                            end
                        end else begin
                            n_state  = settled;
                            n_enable = 1'b0;
                        end
                    end
                    ST_CLOSING: begin
                        if (pos_x < CW'(i_cfg.closed_th)) begin
                            n_step = 1'b1;
                            n_rot  = rot_inc;
                            if (rot_over || (pos_x > CW'(i_cfg.max_th))) begin
                                n_enable = 1'b0;
                                n_state  = settled;
                                n_fail   = 1'b1;
                            end
                        end else begin
                            n_state  = settled;
                            n_enable = 1'b0;
                        end
                    end
                    ST_MOVING: begin
                        if (((r_sign == SIGN_NEG) && (pos_x > tgt_x)) ||
                            ((r_sign == SIGN_POS) && (pos_x < tgt_x))) begin
                            n_step = 1'b1;
                            n_rot  = rot_inc;
                            if (rot_over) begin
                                n_enable = 1'b0;
                                n_state  = settled;
                                n_fail   = 1'b1;
                            end
                        end else begin
                            n_state  = settled;
                            n_enable = 1'b0;
                        end
                    end
                    default: begin
                        // resting states: nothing to do
                    end
                endcase
            end
            KIND_CMD: begin
                unique case (i_item.command)
                    CMD_OPEN: begin
                        n_state  = ST_OPENING;
                        n_dir    = 1'b1;
                        n_enable = 1'b1;
                        n_rot    = '0;
                    end
                    CMD_CLOSE: begin
                        n_state  = ST_CLOSING;
                        n_dir    = 1'b0;
                        n_enable = 1'b1;
                        n_rot    = '0;
                    end
                    CMD_STOP: begin
                        n_state = ST_STOPPING;
                    end
                    CMD_MOVE: begin
                        n_state  = ST_MOVING;
                        n_target = i_item.target;
                        n_rot    = '0;
                        n_enable = 1'b1;
                        if (cmd_tgt_x > pos_x) begin
                            n_sign = SIGN_POS;
                            n_dir  = 1'b0;
                        end else if (cmd_tgt_x < pos_x) begin
                            n_sign = SIGN_NEG;
                            n_dir  = 1'b1;
                        end else begin
                            n_sign = SIGN_ZERO;
                            n_dir  = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_NONE: begin
                // reports the current state only
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_last_pins <= '0;
            r_state     <= ST_OPEN;
            r_rot       <= '0;
            r_target    <= '0;
            r_sign      <= SIGN_ZERO;
            r_enable    <= 1'b0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pos       <= n_pos;
                r_last_pins <= n_last_pins;
                r_state     <= n_state;
                r_rot       <= n_rot;
                r_target    <= n_target;
                r_sign      <= n_sign;
                r_enable    <= n_enable;
                r_dir       <= n_dir;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_step    <= n_step;
            r_fail    <= n_fail;
            r_out_pos <= n_pos_x[15:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_step_pulse   = r_step;
    assign o_motor_enable = r_enable;
    assign o_direction    = r_dir;
    assign o_lock_status  = r_state;
    assign o_position     = r_out_pos;
    assign o_failed       = r_fail;

endmodule

@@ design/encoder_stepper_lock_controller.sv @@
// Path: an accepted item passes two front stages for the percent scaling,
// one queue slot and one result register before its result is valid.
// Throughput: one item per cycle while results are taken; the back stage
// updates the position and motion state for each item that it takes.
// Reset: synchronous, active low; clears pipeline valids, queue and state,
// and loads the threshold registers with their defaults.
// ============================================================================
// encoder_stepper_lock_controller
// Quadrature decoder and stepper lock controller, front/queue/back pipeline.
// ============================================================================
module encoder_stepper_lock_controller #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic                 i_pin_a,
    input  logic                 i_pin_b,
    input  logic [1:0]           i_command,
    input  logic [6:0]           i_target_percent,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_step_pulse,
    output logic                 o_motor_enable,
    output logic                 o_direction,
    output logic [2:0]           o_lock_status,
    output logic signed [15:0]   o_position,
    output logic                 o_failed
);
    import esl_pkg::*;

    t_cfg   r_cfg;
    logic   fq_valid;
    logic   fq_ready;
    t_item  fq_item;
    logic   qb_valid;
    logic   qb_ready;
    t_item  qb_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_th   <= RST_OPEN_TH;
            r_cfg.closed_th <= RST_CLOSED_TH;
            r_cfg.first_th  <= RST_FIRST_TH;
            r_cfg.second_th <= RST_SECOND_TH;
            r_cfg.zero_th   <= RST_ZERO_TH;
            r_cfg.max_th    <= RST_MAX_TH;
            r_cfg.max_rot   <= RST_MAX_ROT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OPEN_TH:   r_cfg.open_th   <= i_cfg_data;
                REG_CLOSED_TH: r_cfg.closed_th <= i_cfg_data;
                REG_FIRST_TH:  r_cfg.first_th  <= i_cfg_data;
                REG_SECOND_TH: r_cfg.second_th <= i_cfg_data;
                REG_ZERO_TH:   r_cfg.zero_th   <= i_cfg_data;
                REG_MAX_TH:    r_cfg.max_th    <= i_cfg_data;
                REG_MAX_ROT:   r_cfg.max_rot   <= i_cfg_data;
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    // Front: accept and pre-compute move targets
    esl_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_kind           (i_kind),
        .i_pin_a          (i_pin_a),
        .i_pin_b          (i_pin_b),
        .i_command        (i_command),
        .i_target_percent (i_target_percent),
        .o_valid          (fq_valid),
        .i_ready          (fq_ready),
        .o_item           (fq_item)
    );

    // Decoupling queue
    esl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    // Back: execute items and hold the result
    esl_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (qb_valid),
        .o_ready        (qb_ready),
        .i_item         (qb_item),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_step_pulse   (o_step_pulse),
        .o_motor_enable (o_motor_enable),
        .o_direction    (o_direction),
        .o_lock_status  (o_lock_status),
        .o_position     (o_position),
        .o_failed       (o_failed)
    );

endmodule

@@ dv/encoder_stepper_lock_controller_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// encoder_stepper_lock_controller_tb
// Self-checking bench for the quadrature decoder and stepper lock controller.
// Items are planned ahead per register setting, driven through the valid/ready
// input channel, and every result is compared field by field against an
// in-bench behavioral copy of the controller. Covers a short directed run,
// random open/close/move sequences with encoder feedback, extreme register
// settings, and a short closing and opening sweep at the widest settings.
// ============================================================================
module encoder_stepper_lock_controller_tb;
    import esl_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int PHASE_ITEMS   = 180;
    localparam int MOTION_TICKS  = 80;
    localparam int SWEEP_TICKS   = 16;
    localparam int PCT_DIV       = 100;
    localparam int POS_TOP       = 32767;
    localparam int POS_BOTTOM    = -32768;
    localparam int ROT_TOP       = 65535;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic       pin_a;
        logic       pin_b;
        logic [1:0] command;
        logic [6:0] pct;
    } stim_t;

    typedef struct packed {
        logic               step;
        logic               enable;
        logic               dir;
        logic [2:0]         status;
        logic signed [15:0] pos;
        logic               failed;
    } report_t;

    typedef struct {
        int         pos;
        logic [1:0] pins;
        logic [2:0] state;
        int         rot;
        int         target;
        logic [1:0] sign;
        logic       enable;
        logic       dir;
    } lock_st_t;

    // DUT connections
    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_cfg_we         = 1'b0;
    logic [2:0]         i_cfg_index      = '0;
    logic [15:0]        i_cfg_data       = '0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_kind           = '0;
    logic               i_pin_a          = 1'b0;
    logic               i_pin_b          = 1'b0;
    logic [1:0]         i_command        = '0;
    logic [6:0]         i_target_percent = '0;
    logic               o_out_valid;
    logic               i_out_ready      = 1'b0;
    logic               o_step_pulse;
    logic               o_motor_enable;
    logic               o_direction;
    logic [2:0]         o_lock_status;
    logic signed [15:0] o_position;
    logic               o_failed;

    // Bench state
    stim_t    items_to_send[$];
    report_t  reports_due[$];
    t_cfg     cfg_now;
    lock_st_t plan_st;
    lock_st_t track_st;
    stim_t    sent_item;
    report_t  accepted_report;
    report_t  want;
    int       send_gap_pct  = 17;
    int       take_gap_pct  = 74;
    int       items_planned = 0;
    int       results_seen  = 0;
    int       mismatches    = 0;
    int       stall_cycles  = 0;
    int       config_sets   = 1;
    int       steps_seen    = 0;
    int       faults_seen   = 0;
    int       pos_low       = 0;
    int       pos_high      = 0;

    encoder_stepper_lock_controller DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_pin_a          (i_pin_a),
        .i_pin_b          (i_pin_b),
        .i_command        (i_command),
        .i_target_percent (i_target_percent),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_step_pulse     (o_step_pulse),
        .o_motor_enable   (o_motor_enable),
        .o_direction      (o_direction),
        .o_lock_status    (o_lock_status),
        .o_position       (o_position),
        .o_failed         (o_failed)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the controller
    // ------------------------------------------------------------------------
    function automatic lock_st_t idle_lock();
        lock_st_t s;
        s.pos    = 0;
        s.pins   = 2'b00;
        s.state  = ST_OPEN;
        s.rot    = 0;
        s.target = 0;
        s.sign   = SIGN_ZERO;
        s.enable = 1'b0;
        s.dir    = 1'b0;
        return s;
    endfunction

    // Resting state from the position
    function automatic logic [2:0] lock_class(input int pos, input t_cfg c);
        if (pos <= int'($signed(c.first_th))) return ST_OPEN;
        if (pos >= int'($signed(c.second_th))) return ST_CLOSED;
        return ST_FIRSTLOCK;
    endfunction

    task automatic lock_step(inout lock_st_t s, input t_cfg c, input stim_t it,
                             output report_t r);
        logic [3:0] trans;
        logic       going;
        logic       over;
        int         pct;
        int         delta;
        r     = '0;
        going = 1'b0;
        over  = 1'b0;
        case (it.kind)
            KIND_ENC: begin
                // 4x decode of old/new pin pair, saturating count
                trans = {s.pins, it.pin_a, it.pin_b};
                case (trans)
                    4'b1101, 4'b0100, 4'b0010, 4'b1011: if (s.pos < POS_TOP) s.pos++;
                    4'b1110, 4'b0111, 4'b0001, 4'b1000: if (s.pos > POS_BOTTOM) s.pos--;
                    default: ;
                endcase
                s.pins = {it.pin_a, it.pin_b};
            end
            KIND_TICK: begin
                case (s.state)
                    ST_STOPPING: begin
                        s.state  = lock_class(s.pos, c);
                        s.enable = 1'b0;
                    end
                    ST_OPENING, ST_CLOSING, ST_MOVING: begin
                        // keep stepping until the end point is reached
                        if (s.state == ST_OPENING)
                            going = s.pos > int'($signed(c.open_th));
                        else if (s.state == ST_CLOSING)
                            going = s.pos < int'($signed(c.closed_th));
                        else
                            going = (s.sign == SIGN_NEG && s.pos > s.target) ||
                                    (s.sign == SIGN_POS && s.pos < s.target);
                        if (going) begin
                            r.step = 1'b1;
                            // limit check uses the count from before this step
                            over = s.rot > int'(c.max_rot);
                            if (s.rot < ROT_TOP) s.rot++;
                            if (s.state == ST_OPENING)
                                over = over || s.pos < int'($signed(c.zero_th));
                            if (s.state == ST_CLOSING)
                                over = over || s.pos > int'($signed(c.max_th));
                            if (over) begin
                                s.enable = 1'b0;
                                s.state  = lock_class(s.pos, c);
                                r.failed = 1'b1;
                            end
                        end else begin
                            s.state  = lock_class(s.pos, c);
                            s.enable = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_CMD: begin
                case (it.command)
                    CMD_OPEN: begin
                        s.state  = ST_OPENING;
                        s.dir    = 1'b1;
                        s.enable = 1'b1;
                        s.rot    = 0;
                    end
                    CMD_CLOSE: begin
                        s.state  = ST_CLOSING;
                        s.dir    = 1'b0;
                        s.enable = 1'b1;
                        s.rot    = 0;
                    end
                    CMD_STOP: s.state = ST_STOPPING;
                    default: begin
                        // percent move, clipped at 100, truncated toward zero
                        pct      = (it.pct > PCT_MAX) ? int'(PCT_MAX) : int'(it.pct);
                        s.target = pct * int'($signed(c.closed_th)) / PCT_DIV;
                        delta    = s.target - s.pos;
                        s.sign   = (delta > 0) ? SIGN_POS : ((delta < 0) ? SIGN_NEG : SIGN_ZERO);
                        s.rot    = 0;
                        s.dir    = (delta < 0);
                        s.enable = 1'b1;
                        s.state  = ST_MOVING;
                    end
                endcase
            end
            default: ;
        endcase
        r.enable = s.enable;
        r.dir    = s.dir;
        r.status = s.state;
        r.pos    = s.pos[15:0];
    endtask

    // ------------------------------------------------------------------------
    // Item planning: a second copy of the state steers the sequences
    // ------------------------------------------------------------------------
    task automatic plan_item(input stim_t it);
        report_t unused;
        lock_step(plan_st, cfg_now, it, unused);
        items_to_send.push_back(it);
        items_planned++;
    endtask

    task automatic plan_tick();
        stim_t it;
        it      = stim_t'(13'($urandom));
        it.kind = KIND_TICK;
        plan_item(it);
    endtask

    task automatic plan_cmd(input logic [1:0] cmd, input logic [6:0] pct);
        stim_t it;
        it         = stim_t'(13'($urandom));
        it.kind    = KIND_CMD;
        it.command = cmd;
        it.pct     = pct;
        plan_item(it);
    endtask

    // One clean quadrature edge, up or down
    task automatic plan_step(input bit up);
        stim_t      it;
        logic [1:0] nxt;
        case (plan_st.pins)
            2'b00:   nxt = up ? 2'b10 : 2'b01;
            2'b10:   nxt = up ? 2'b11 : 2'b00;
            2'b11:   nxt = up ? 2'b01 : 2'b10;
            default: nxt = up ? 2'b00 : 2'b11;
        endcase
        it       = stim_t'(13'($urandom));
        it.kind  = KIND_ENC;
        it.pin_a = nxt[1];
        it.pin_b = nxt[0];
        plan_item(it);
    endtask

    function automatic logic [6:0] rand_pct();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) return 7'($urandom_range(101, 127));
        if (r == 2) return 7'd0;
        if (r == 3) return PCT_MAX;
        return 7'($urandom_range(0, 100));
    endfunction

    task automatic plan_random(input int n);
        int    goal;
        int    pick;
        int    r;
        int    k;
        stim_t it;
        goal = items_planned + n;
        while (items_planned < goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // motion with encoder feedback that mostly follows the motor
                r = $urandom_range(0, 9);
                plan_cmd((r < 3) ? CMD_OPEN : ((r < 6) ? CMD_CLOSE : CMD_MOVE), rand_pct());
                k = 0;
                while ((plan_st.state == ST_OPENING || plan_st.state == ST_CLOSING ||
                        plan_st.state == ST_MOVING) && k < MOTION_TICKS) begin
                    plan_tick();
                    r = $urandom_range(0, 99);
                    if (r < 75) begin
                        plan_step(!plan_st.dir);
                    end else if (r < 85) begin
                        plan_step(!plan_st.dir);
                        plan_step(!plan_st.dir);
                    end else if (r < 90) begin
                        plan_step(plan_st.dir);
                    end else if (r < 93) begin
                        plan_cmd(2'($urandom_range(0, 3)), rand_pct());
                    end
                    k++;
                end
                if (plan_st.state == ST_STOPPING) plan_tick();
            end else if (pick == 7) begin
                // noise: raw items, pins jumping freely
                repeat ($urandom_range(1, 6)) begin
                    it = stim_t'(13'($urandom));
                    plan_item(it);
                end
            end else if (pick == 8) begin
                plan_cmd(CMD_STOP, rand_pct());
                plan_tick();
            end else begin
                plan_tick();
                it      = stim_t'(13'($urandom));
                it.kind = KIND_NONE;
                plan_item(it);
            end
        end
    endtask

    // Thresholds scattered around the current position
    function automatic t_cfg small_config();
        t_cfg c;
        int   base;
        int   span;
        int   op;
        int   cl;
        base = plan_st.pos;
        if (base > 32000) base = 32000;
        if (base < -32000) base = -32000;
        span = $urandom_range(8, 60);
        op   = base - int'($urandom_range(0, span / 2));
        cl   = base + int'($urandom_range(span / 2, span));
        c.open_th   = 16'(op);
        c.closed_th = 16'(cl);
        c.first_th  = 16'(op + int'($urandom_range(0, span / 2)));
        c.second_th = 16'(cl - int'($urandom_range(0, span / 2)));
        c.zero_th   = 16'(op - int'($urandom_range(0, 2)) +
                          (($urandom_range(0, 5) == 0) ? 4 : 0));
        c.max_th    = 16'(cl + int'($urandom_range(0, 2)) -
                          (($urandom_range(0, 5) == 0) ? 4 : 0));
        c.max_rot   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3)) :
                                                    16'($urandom_range(span, 4 * span));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Register writes and phase sequencing
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_OPEN_TH:   cfg_now.open_th   = val;
            REG_CLOSED_TH: cfg_now.closed_th = val;
            REG_FIRST_TH:  cfg_now.first_th  = val;
            REG_SECOND_TH: cfg_now.second_th = val;
            REG_ZERO_TH:   cfg_now.zero_th   = val;
            REG_MAX_TH:    cfg_now.max_th    = val;
            REG_MAX_ROT:   cfg_now.max_rot   = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(REG_OPEN_TH,   c.open_th);
        write_reg(REG_CLOSED_TH, c.closed_th);
        write_reg(REG_FIRST_TH,  c.first_th);
        write_reg(REG_SECOND_TH, c.second_th);
        write_reg(REG_ZERO_TH,   c.zero_th);
        write_reg(REG_MAX_TH,    c.max_th);
        write_reg(REG_MAX_ROT,   c.max_rot);
        // index past the last register must be ignored
        write_reg(REG_UNUSED, 16'($urandom));
        config_sets++;
    endtask

    // Hold off until every planned item has its result back
    task automatic drain();
        while (results_seen < items_planned) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: predicts on acceptance, then loads the next item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                lock_step(track_st, cfg_now, sent_item, accepted_report);
                reports_due.push_back(accepted_report);
            end
            if (!i_in_valid || o_in_ready) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    sent_item        = items_to_send.pop_front();
                    i_kind           <= sent_item.kind;
                    i_pin_a          <= sent_item.pin_a;
                    i_pin_b          <= sent_item.pin_b;
                    i_command        <= sent_item.command;
                    i_target_percent <= sent_item.pct;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= take_gap_pct);
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [16:0] exp_val,
                               input logic signed [16:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (reports_due.size() == 0) begin
                $error("result with no item outstanding");
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("step_pulse",   want.step,           o_step_pulse);
                check_field("motor_enable", want.enable,         o_motor_enable);
                check_field("direction",    want.dir,            o_direction);
                check_field("lock_status",  want.status,         o_lock_status);
                check_field("position",     $signed(want.pos),   $signed(o_position));
                check_field("failed",       want.failed,         o_failed);
                if (want.step) steps_seen++;
                if (want.failed) faults_seen++;
                if (int'($signed(want.pos)) < pos_low) pos_low = int'($signed(want.pos));
                if (int'($signed(want.pos)) > pos_high) pos_high = int'($signed(want.pos));
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cfg c;
        stim_t it;
        int   phase;

        track_st          = idle_lock();
        plan_st           = idle_lock();
        cfg_now.open_th   = RST_OPEN_TH;
        cfg_now.closed_th = RST_CLOSED_TH;
        cfg_now.first_th  = RST_FIRST_TH;
        cfg_now.second_th = RST_SECOND_TH;
        cfg_now.zero_th   = RST_ZERO_TH;
        cfg_now.max_th    = RST_MAX_TH;
        cfg_now.max_rot   = RST_MAX_ROT;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unused kind, idle tick, zero move, clean and jumping
        // encoder edges, commands mid-motion, clipped percent, stop
        it = '{kind: KIND_NONE, pin_a: 1'b1, pin_b: 1'b1, command: CMD_MOVE, pct: 7'd127};
        plan_item(it);
        plan_tick();
        plan_cmd(CMD_MOVE, 7'd0);
        plan_tick();
        repeat (3) plan_step(1'b1);
        it       = stim_t'(13'($urandom));
        it.kind  = KIND_ENC;
        it.pin_a = ~plan_st.pins[1];
        it.pin_b = ~plan_st.pins[0];
        plan_item(it);
        plan_cmd(CMD_OPEN, 7'd127);
        plan_tick();
        plan_cmd(CMD_CLOSE, 7'd0);
        plan_tick();
        plan_cmd(CMD_MOVE, 7'd127);
        plan_tick();
        plan_cmd(CMD_STOP, 7'd0);
        plan_tick();
        plan_cmd(CMD_MOVE, 7'd50);
        plan_step(1'b0);
        plan_step(1'b0);
        plan_tick();
        plan_cmd(CMD_OPEN, 7'd0);
        repeat (2) plan_step(1'b0);
        plan_tick();
        plan_tick();
        drain();

        // Random phases: receiver slow first, then sender slow, then full rate
        for (phase = 1; phase <= 6; phase++) begin
            if (phase == 3) begin
                send_gap_pct = 74;
                take_gap_pct = 17;
            end else if (phase == 5) begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            if (phase == 2) begin
                c.open_th   = 16'sh7FFF;
                c.closed_th = 16'sh8000;
                c.first_th  = 16'sh8000;
                c.second_th = 16'sh7FFF;
                c.zero_th   = 16'sh8000;
                c.max_th    = 16'sh7FFF;
                c.max_rot   = 16'h0000;
            end else if (phase == 4) begin
                c.open_th   = 16'sh8000;
                c.closed_th = 16'sh7FFF;
                c.first_th  = 16'sh7FFF;
                c.second_th = 16'sh8000;
                c.zero_th   = 16'sh7FFF;
                c.max_th    = 16'sh8000;
                c.max_rot   = 16'hFFFF;
            end else begin
                c = small_config();
            end
            apply_config(c);
            plan_random(PHASE_ITEMS);
            drain();
        end

        // Short sweep: close and open at the widest thresholds, stop each run
        c.open_th   = 16'sh8000;
        c.closed_th = 16'sh7FFF;
        c.first_th  = -16'sd100;
        c.second_th = 16'sd100;
        c.zero_th   = 16'sh8000;
        c.max_th    = 16'sh7FFF;
        c.max_rot   = 16'hFFFF;
        apply_config(c);
        plan_cmd(CMD_CLOSE, 7'd0);
        repeat (SWEEP_TICKS) begin
            plan_tick();
            plan_step(1'b1);
        end
        plan_cmd(CMD_STOP, 7'd0);
        plan_tick();
        plan_cmd(CMD_OPEN, 7'd0);
        repeat (SWEEP_TICKS) begin
            plan_tick();
            plan_step(1'b0);
        end
        plan_cmd(CMD_STOP, 7'd0);
        plan_tick();
        drain();

        if (reports_due.size() != 0) begin
            $error("%0d results never arrived", reports_due.size());
            mismatches++;
        end
        $display("Checked %0d results over %0d register settings: %0d step pulses, %0d faults.",
                 results_seen, config_sets, steps_seen, faults_seen);
        $display("Positions reported ranged from %0d to %0d under three stall mixes.",
                 pos_low, pos_high);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
